// File: hw/rtl/tmtw_pkg.sv
// constants, codes and state type for the text mode terminal writer
// no dependencies; imported by text_mode_terminal_writer_top
package tmtw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int PTR_W  = $clog2(CELL_COUNT + 1);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_SET   = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/text_mode_terminal_writer_top.sv
// text mode terminal writer: 80x25 cell store, cursor, put/clear/set/read requests
// depends on tmtw_pkg
//
// One request is worked at a time; the 2000-cell screen store is a single
// synchronous memory (one write and one read port, registered read). After reset
// a clearing pass fills the store with blanks before the first request is taken
// (in_stall stays high; register writes are taken as usual). Put character and
// set cursor pass through a done state; read cell adds a read state for the
// registered memory read. Clear screen sweeps the store one cell a cycle. A put
// character that scrolls copies rows 1..24 up one cell a cycle through the memory
// read port and then blanks the bottom row. A finished result waits in the
// output register while the next request is accepted.
module text_mode_terminal_writer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [7:0]                     write_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     func,
  input  logic [7:0]                     char_code,
  input  logic [7:0]                     attribute,
  input  logic [tmtw_pkg::COL_W-1:0]     column,
  input  logic [tmtw_pkg::ROW_W-1:0]     row,
  input  logic [tmtw_pkg::ADDR_W-1:0]    cell_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tmtw_pkg::ADDR_W-1:0]    cursor_position,
  output logic [tmtw_pkg::CELL_W-1:0]    read_data,
  output logic                           scrolled
);
  import tmtw_pkg::*;

  logic [CELL_W-1:0] screen [CELL_COUNT];

  state_t            state, state_next;
  logic [PTR_W-1:0]  ptr, ptr_next;
  logic [7:0]        blank_attribute;
  logic [COL_W-1:0]  cursor_col, cursor_col_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic              addr_ok, addr_ok_next;
  logic [CELL_W-1:0] res_read, res_read_next;
  logic              res_scrolled, res_scrolled_next;
  logic              out_valid_next;
  logic [ADDR_W-1:0] cursor_position_next;
  logic [CELL_W-1:0] read_data_next;
  logic              scrolled_next;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic [COL_W:0]    col_adv;
  logic [ROW_W:0]    row_adv;
  logic              scroll_hit;
  logic              is_control;
  logic [ADDR_W-1:0] cur_idx;
  logic [CELL_W-1:0] blank_cell;

  // screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= screen[mem_raddr];
    end
  end

  assign blank_cell = {blank_attribute, CH_SPACE};
  assign cur_idx    = ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col);
  assign in_stall   = (state != S_IDLE);
  assign is_control = (char_code == CH_NEWLINE) || (char_code == CH_RETURN) ||
                      (char_code == CH_TAB);

  // cursor motion for put character
  always_comb begin
    col_adv = {1'b0, cursor_col};
    row_adv = {1'b0, cursor_row};
    case (char_code)
      CH_NEWLINE: begin
        col_adv = '0;
        row_adv = row_adv + 1'b1;
      end
      CH_RETURN: col_adv = '0;
      CH_TAB: begin
        col_adv = col_adv + (COL_W+1)'(TAB_STOP) - (col_adv % (COL_W+1)'(TAB_STOP));
      end
      default: col_adv = col_adv + 1'b1;
    endcase
    if (col_adv >= (COL_W+1)'(COLUMNS)) begin
      col_adv = '0;
      row_adv = row_adv + 1'b1;
    end
    scroll_hit = (row_adv >= (ROW_W+1)'(ROWS));
    if (scroll_hit) begin
      row_adv = (ROW_W+1)'(ROWS - 1);
    end
  end

  always_comb begin
    state_next           = state;
    ptr_next             = ptr;
    cursor_col_next      = cursor_col;
    cursor_row_next      = cursor_row;
    addr_ok_next         = addr_ok;
    res_read_next        = res_read;
    res_scrolled_next    = res_scrolled;
    out_valid_next       = out_valid && out_stall;
    cursor_position_next = cursor_position;
    read_data_next       = read_data;
    scrolled_next        = scrolled;
    mem_we               = 1'b0;
    mem_waddr            = ADDR_W'(ptr);
    mem_wdata            = blank_cell;
    mem_re               = 1'b0;
    mem_raddr            = ADDR_W'(ptr);

    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, CH_SPACE};
        if (ptr == PTR_W'(CELL_COUNT - 1)) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_read_next     = '0;
          res_scrolled_next = 1'b0;
          unique case (func_t'(func))
            FUNC_PUT: begin
              if (!is_control) begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = {attribute, char_code};
              end
              cursor_col_next   = COL_W'(col_adv);
              cursor_row_next   = ROW_W'(row_adv);
              res_scrolled_next = scroll_hit;
              if (scroll_hit) begin
                ptr_next   = PTR_W'(COLUMNS);
                state_next = S_SCROLL;
              end else begin
                state_next = S_DONE;
              end
            end
            FUNC_CLEAR: begin
              cursor_col_next = '0;
              cursor_row_next = '0;
              ptr_next        = '0;
              state_next      = S_FILL;
            end
            FUNC_SET: begin
              cursor_col_next = (column > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : column;
              cursor_row_next = (row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row;
              state_next      = S_DONE;
            end
            FUNC_READ: begin
              mem_re       = 1'b1;
              mem_raddr    = cell_address;
              addr_ok_next = (cell_address < ADDR_W'(CELL_COUNT));
              state_next   = S_READ;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_READ: begin
        res_read_next = addr_ok ? mem_rdata : '0;
        state_next    = S_DONE;
      end
      S_SCROLL: begin
        // read runs one cell ahead of the write one row up
        if (ptr != PTR_W'(CELL_COUNT)) begin
          mem_re = 1'b1;
        end
        if (ptr != PTR_W'(COLUMNS)) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(ptr - PTR_W'(COLUMNS + 1));
          mem_wdata = mem_rdata;
        end
        if (ptr == PTR_W'(CELL_COUNT)) begin
          ptr_next   = PTR_W'((ROWS - 1) * COLUMNS);
          state_next = S_FILL;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (ptr == PTR_W'(CELL_COUNT - 1)) begin
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next       = 1'b1;
          cursor_position_next = cur_idx;
          read_data_next       = res_read;
          scrolled_next        = res_scrolled;
          state_next           = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INIT;
      ptr             <= '0;
      blank_attribute <= RESET_ATTR;
      cursor_col      <= '0;
      cursor_row      <= '0;
      out_valid       <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      out_valid  <= out_valid_next;
      if (write_enable) begin
        blank_attribute <= write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_ok         <= addr_ok_next;
    res_read        <= res_read_next;
    res_scrolled    <= res_scrolled_next;
    cursor_position <= cursor_position_next;
    read_data       <= read_data_next;
    scrolled        <= scrolled_next;
  end

  // cursor is always on screen when a request can be taken
  assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (cursor_col < COL_W'(COLUMNS)) && (cursor_row < ROW_W'(ROWS)))
    else $error("cursor off screen at request accept");

  // scroll copy never reads and writes the same cell in one cycle
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write collide on one cell");

  // a scrolling result leaves the cursor on the bottom row
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_position >= ADDR_W'((ROWS - 1) * COLUMNS)))
    else $error("scroll result with cursor above bottom row");

  // clear, scroll and reset-time fills keep the cell pointer inside the store
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL || state == S_INIT) |-> (ptr < PTR_W'(CELL_COUNT)))
    else $error("fill pointer past end of store");

endmodule
